// ----- hw/rtl/nmwa_pkg.sv -----
// Shared types and constants of the nearest monitor work area block.
`timescale 1ns / 1ps

package nmwa_pkg;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_DOCK_SIZE    = 3'd2,
        CFG_DOCK_ON_TOP  = 3'd3,
        CFG_EDGE_MARGIN  = 3'd4
    } t_cfg_addr;

    // Register values after reset.
    localparam logic [15:0] RST_FRAME_WIDTH  = 16'd1024;
    localparam logic [15:0] RST_FRAME_HEIGHT = 16'd768;
    localparam logic [15:0] RST_DOCK_SIZE    = 16'd0;
    localparam logic        RST_DOCK_ON_TOP  = 1'b0;
    localparam logic [7:0]  RST_EDGE_MARGIN  = 8'd6;

    // Item kinds; both remaining codes are queries.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_ANSWERED = 2'd0,
        STS_CLEARED  = 2'd1,
        STS_STORED   = 2'd2,
        STS_DROPPED  = 2'd3
    } t_status;

    // Payload and datapath widths.
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned COORD_W    = 18;
    localparam int unsigned DIFF_W     = 17;
    localparam int unsigned SQ_W       = 2 * DIFF_W;
    localparam int unsigned DIST_W     = SQ_W + 1;

endpackage

// ----- hw/rtl/nearest_monitor_work_area.sv -----
// Top level: monitor table with a nearest-monitor work area query.
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Contents
// --------  ---  -------------------------------  ----------------------------------------
// input     in   s_axis_tvalid/tready/tdata/tuser  kind in tuser; rectangle in tdata
// result    out  m_axis_tvalid/tready/tdata/tuser  status in tuser; sel and work area in tdata
// config    in   i_cfg_we/i_cfg_addr/i_cfg_wdata   register writes, no read-back
//
// A clear or an append item goes from idle straight to done. A query steps each stored
// monitor through read, diff, square x, square y and compare (an empty table skips the scan):
// one squaring multiplier is shared for dx and dy and walks the table one monitor at a time.
// Reset clears the table count, the sequencer, the output valid flag and the
// configuration registers; the table storage itself needs no clearing pass.
// A finished result waits in the output register while the next item is taken;
// only a second result that cannot be stored holds the sequencer.

module nearest_monitor_work_area #(
    parameter int MAX_MONITORS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x[15:0], pos_y[31:16], size_w[47:32], size_h[63:48]
    input  logic [nmwa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // monitor_sel[3:0], area_x[21:4], area_y[39:22], area_w[56:40], area_h[73:57]
    output logic [nmwa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]                       m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [nmwa_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [nmwa_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int CW = $clog2(MAX_MONITORS + 1);
    localparam int IW = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;
    localparam int XW = nmwa_pkg::COORD_W;
    localparam int DW = nmwa_pkg::DIFF_W;
    localparam int PW = nmwa_pkg::SQ_W;
    localparam int SW = nmwa_pkg::DIST_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RD    = 9'b000000010,
        ST_DIFF  = 9'b000000100,
        ST_SQX   = 9'b000001000,
        ST_SQY   = 9'b000010000,
        ST_CMP   = 9'b000100000,
        ST_EDGE  = 9'b001000000,
        ST_CLAMP = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    // Monitor table: one entry packs x, y, w, h as the input tdata does.
    logic [nmwa_pkg::IN_DATA_W-1:0] r_mem [MAX_MONITORS];
    logic [nmwa_pkg::IN_DATA_W-1:0] r_rd;

    // Control state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_total, n_total;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_out_valid, n_out_valid;

    // Configuration.
    logic [15:0]     r_frame_width, r_frame_height, r_dock_size;
    logic            r_dock_on_top;
    logic [7:0]      r_edge_margin;

    // Query datapath.
    logic signed [XW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [DW-1:0]        r_dx, n_dx, r_dy, n_dy;
    logic [PW-1:0]        r_prod, n_prod, r_sum, n_sum;
    logic [SW-1:0]        r_best_d, n_best_d;
    logic [IW-1:0]        r_sel, n_sel;
    logic [nmwa_pkg::IN_DATA_W-1:0] r_mon, n_mon;
    logic signed [XW-1:0] r_left, n_left, r_top, n_top;
    logic signed [XW-1:0] r_right, n_right, r_bottom, n_bottom;

    // Result staging and output register.
    logic [1:0]           r_res_status, n_res_status;
    logic [3:0]           r_res_sel, n_res_sel;
    logic signed [XW-1:0] r_res_x, n_res_x, r_res_y, n_res_y;
    logic [16:0]          r_res_w, n_res_w, r_res_h, n_res_h;
    logic [1:0]           r_out_status, n_out_status;
    logic [nmwa_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Combinational helpers.
    logic                 s_fire;
    logic                 append_ok;
    logic [DW-1:0]        mul_op;
    logic [PW-1:0]        mul_prod;
    logic [SW-1:0]        dist_sum;
    logic signed [XW-1:0] e_x, e_y, e_xe, e_ye, d_x, d_y;
    logic signed [XW-1:0] m_x, m_y, m_xe, m_ye, mg, fw, fh, dh, dock_lo, dock_hi;
    logic signed [XW-1:0] e_left, e_top, e_right, e_bottom, area_w, area_h;
    logic [15:0]          dh16;
    logic                 skip, overlap;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    assign append_ok = (s_axis_tdata[47:32] != 16'd0) && (s_axis_tdata[63:48] != 16'd0)
                    && (r_total < MAX_MONITORS);

    // The one shared squaring unit: dx in the SQX state, dy in the SQY state that follows.
    assign mul_op   = (r_state == ST_SQX) ? r_dx : r_dy;
    assign mul_prod = {{DW{1'b0}}, mul_op} * {{DW{1'b0}}, mul_op};
    assign dist_sum = {1'b0, r_sum} + {1'b0, r_prod};

    // Distance from the query centre to the table entry under the read port.
    always_comb begin
        e_x  = $signed({{2{r_rd[15]}}, r_rd[15:0]});
        e_y  = $signed({{2{r_rd[31]}}, r_rd[31:16]});
        e_xe = e_x + $signed({2'b00, r_rd[47:32]});
        e_ye = e_y + $signed({2'b00, r_rd[63:48]});
        if (r_cx < e_x) begin
            d_x = e_x - r_cx;
        end else if (r_cx >= e_xe) begin
            d_x = r_cx - e_xe + 18'sd1;
        end else begin
            d_x = '0;
        end
        if (r_cy < e_y) begin
            d_y = e_y - r_cy;
        end else if (r_cy >= e_ye) begin
            d_y = r_cy - e_ye + 18'sd1;
        end else begin
            d_y = '0;
        end
    end

    // Margin inset and dock cut of the chosen monitor.
    always_comb begin
        m_x     = $signed({{2{r_mon[15]}}, r_mon[15:0]});
        m_y     = $signed({{2{r_mon[31]}}, r_mon[31:16]});
        m_xe    = m_x + $signed({2'b00, r_mon[47:32]});
        m_ye    = m_y + $signed({2'b00, r_mon[63:48]});
        mg      = $signed({10'd0, r_edge_margin});
        fw      = $signed({2'b00, r_frame_width});
        fh      = $signed({2'b00, r_frame_height});
        dh16    = (r_dock_size > r_frame_height) ? r_frame_height : r_dock_size;
        dh      = $signed({2'b00, dh16});
        dock_lo = r_dock_on_top ? 18'sd0 : (fh - dh);
        dock_hi = dock_lo + dh;
        // A monitor with no area (only the empty framebuffer) passes unchanged.
        skip    = (r_mon[47:32] == 16'd0) || (r_mon[63:48] == 16'd0);
        overlap = (m_x < fw) && (18'sd0 < m_xe) && (m_y < dock_hi) && (dock_lo < m_ye);
        e_left   = skip ? m_x  : (m_x + mg);
        e_top    = skip ? m_y  : (m_y + mg);
        e_right  = skip ? m_xe : (m_xe - mg);
        e_bottom = skip ? m_ye : (m_ye - mg);
        if (!skip && overlap) begin
            if (r_dock_on_top) begin
                e_top = dh + mg;
            end else begin
                e_bottom = dock_lo - mg;
            end
        end
        area_w = r_right - r_left;
        area_h = r_bottom - r_top;
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_idx        = r_idx;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_prod       = r_prod;
        n_sum        = r_sum;
        n_best_d     = r_best_d;
        n_sel        = r_sel;
        n_mon        = r_mon;
        n_left       = r_left;
        n_top        = r_top;
        n_right      = r_right;
        n_bottom     = r_bottom;
        n_res_status = r_res_status;
        n_res_sel    = r_res_sel;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_w      = r_res_w;
        n_res_h      = r_res_h;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_res_sel = '0;
                    n_res_x   = '0;
                    n_res_y   = '0;
                    n_res_w   = '0;
                    n_res_h   = '0;
                    if (s_axis_tuser == nmwa_pkg::KIND_CLEAR) begin
                        n_total      = '0;
                        n_res_status = nmwa_pkg::STS_CLEARED;
                        n_state      = ST_DONE;
                    end else if (s_axis_tuser == nmwa_pkg::KIND_APPEND) begin
                        if (append_ok) begin
                            n_total      = r_total + CW'(1);
                            n_res_status = nmwa_pkg::STS_STORED;
                        end else begin
                            n_res_status = nmwa_pkg::STS_DROPPED;
                        end
                        n_state = ST_DONE;
                    end else begin
                        // Centre of the query rectangle, halves rounded down.
                        n_cx     = $signed({{2{s_axis_tdata[15]}}, s_axis_tdata[15:0]})
                                 + $signed({3'b000, s_axis_tdata[47:33]});
                        n_cy     = $signed({{2{s_axis_tdata[31]}}, s_axis_tdata[31:16]})
                                 + $signed({3'b000, s_axis_tdata[63:49]});
                        n_idx    = '0;
                        n_sel    = '0;
                        n_best_d = '1;
                        if (r_total == '0) begin
                            n_mon   = {r_frame_height, r_frame_width, 32'd0};
                            n_state = ST_EDGE;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_dx    = d_x[DW-1:0];
                n_dy    = d_y[DW-1:0];
                n_state = ST_SQX;
            end
            ST_SQX: begin
                n_prod  = mul_prod;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_sum   = r_prod;
                n_prod  = mul_prod;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // Strictly smaller keeps the first of equal distances, and a
                // containing monitor is the first one at distance zero.
                if (dist_sum < r_best_d) begin
                    n_best_d = dist_sum;
                    n_sel    = r_idx[IW-1:0];
                    n_mon    = r_rd;
                end
                if (r_idx + CW'(1) == r_total) begin
                    n_state = ST_EDGE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_RD;
                end
            end
            ST_EDGE: begin
                n_left   = e_left;
                n_top    = e_top;
                n_right  = e_right;
                n_bottom = e_bottom;
                n_state  = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_res_status = nmwa_pkg::STS_ANSWERED;
                n_res_sel    = 4'(r_sel);
                n_res_x      = r_left;
                n_res_y      = r_top;
                n_res_w      = (r_right < r_left) ? 17'd0 : area_w[16:0];
                n_res_h      = (r_bottom < r_top) ? 17'd0 : area_h[16:0];
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = {6'd0, r_res_h, r_res_w, r_res_y, r_res_x, r_res_sel};
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_total        <= '0;
            r_out_valid    <= 1'b0;
            r_frame_width  <= nmwa_pkg::RST_FRAME_WIDTH;
            r_frame_height <= nmwa_pkg::RST_FRAME_HEIGHT;
            r_dock_size    <= nmwa_pkg::RST_DOCK_SIZE;
            r_dock_on_top  <= nmwa_pkg::RST_DOCK_ON_TOP;
            r_edge_margin  <= nmwa_pkg::RST_EDGE_MARGIN;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (nmwa_pkg::t_cfg_addr'(i_cfg_addr))
                    nmwa_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                    nmwa_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                    nmwa_pkg::CFG_DOCK_SIZE:    r_dock_size    <= i_cfg_wdata;
                    nmwa_pkg::CFG_DOCK_ON_TOP:  r_dock_on_top  <= i_cfg_wdata[0];
                    nmwa_pkg::CFG_EDGE_MARGIN:  r_edge_margin  <= i_cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_prod       <= n_prod;
        r_sum        <= n_sum;
        r_best_d     <= n_best_d;
        r_sel        <= n_sel;
        r_mon        <= n_mon;
        r_left       <= n_left;
        r_top        <= n_top;
        r_right      <= n_right;
        r_bottom     <= n_bottom;
        r_res_status <= n_res_status;
        r_res_sel    <= n_res_sel;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_w      <= n_res_w;
        r_res_h      <= n_res_h;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    // Table memory: one write port, one registered read port at the scan index.
    always_ff @(posedge i_clk) begin
        if (s_fire && (s_axis_tuser == nmwa_pkg::KIND_APPEND) && append_ok) begin
            r_mem[r_total[IW-1:0]] <= s_axis_tdata;
        end
        r_rd <= r_mem[r_idx[IW-1:0]];
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_MONITORS)
        else $error("monitor count above table depth");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIFF || r_state == ST_CMP) |-> (r_idx < r_total))
        else $error("scan index outside the stored monitors");

    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tuser != nmwa_pkg::KIND_CLEAR
                && s_axis_tuser != nmwa_pkg::KIND_APPEND && r_total == '0)
        |=> (r_state == ST_EDGE))
        else $error("query on an empty table did not skip the scan");

    a_best_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |=> (r_best_d <= $past(r_best_d)))
        else $error("best distance grew during the scan");

    a_nonquery_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != nmwa_pkg::STS_ANSWERED) |-> (m_axis_tdata == '0))
        else $error("table item result carries nonzero area fields");

endmodule
